// File: src/shortest_path_tree_engine_top_defines.svh
// ----------------------------------------------------------------------------
// Shortest path tree engine: assertion macros
// Shared macros for concurrent checks on the engine's ports.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_PATH_TREE_ENGINE_TOP_DEFINES_SVH
`define SHORTEST_PATH_TREE_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SPTE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always active
`define SPTE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/spte_pkg.sv
// ----------------------------------------------------------------------------
// Shortest path tree engine package
// Item types, request codes and stored record formats.
// ----------------------------------------------------------------------------
package spte_pkg;

    localparam int unsigned DEF_MAX_NODES = 64;
    localparam int unsigned DEF_MAX_EDGES = 256;

    localparam int unsigned NODE_FW  = 6;
    localparam int unsigned COORD_W  = 24;
    localparam int unsigned WEIGHT_W = 24;
    localparam int unsigned COST_W   = 32;
    localparam int unsigned DIST_W   = 50;

    localparam logic [1:0] REQ_NODE  = 2'd0;
    localparam logic [1:0] REQ_EDGE  = 2'd1;
    localparam logic [1:0] REQ_RUN   = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [COST_W-1:0] COST_NONE = '1;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [NODE_FW-1:0]         node_a;
        logic [NODE_FW-1:0]         node_b;
        logic [WEIGHT_W-1:0]        weight;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
    } t_in_item;

    typedef struct packed {
        logic [NODE_FW-1:0] node_index;
        logic               reached;
        logic               is_start;
        logic [NODE_FW-1:0] prev_node;
        logic [COST_W-1:0]  path_cost;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_pos;

    typedef struct packed {
        logic [NODE_FW-1:0]  dst;
        logic [NODE_FW-1:0]  src;
        logic [WEIGHT_W-1:0] weight;
    } t_edge;

    typedef struct packed {
        logic               prev_vld;
        logic [NODE_FW-1:0] prev;
        logic [COST_W-1:0]  cost;
    } t_label;

    localparam t_label LABEL_NONE = '{prev_vld: 1'b0, prev: '0, cost: COST_NONE};

    typedef struct packed {
        logic               clear;
        logic               rd;
        logic [NODE_FW-1:0] rd_addr;
        logic               wr;
        logic [NODE_FW-1:0] wr_addr;
        t_label             wr_data;
        logic               push;
        logic [NODE_FW-1:0] push_node;
        logic               pop;
        logic               unmark;
        logic [NODE_FW-1:0] unmark_node;
    } t_lbl_cmd;

endpackage

// File: src/shortest_path_tree_engine_top.sv
// ----------------------------------------------------------------------------
// Shortest path tree engine
// Graph loader, nearest-start search and label-correcting relaxation.
// ----------------------------------------------------------------------------
// Use: items arrive on i_valid/o_ready with payload i_in. Node, edge and
// clear items give no result; they may follow each other every cycle.
// A run item gives MAX_NODES results on o_valid/i_ready, node 0 first, the
// last one flagged by last.
// A run first searches for the start node, one node per cycle through a
// two-stage distance pipeline, then relaxes edges: every queue pop sweeps
// all stored edges one entry at a time. Results then leave one at a time,
// each after its label memory read.
// o_ready is low for the whole run, until the final result is loaded into the
// output register; the next item may be taken while that result waits.
// When the receiver stalls, the output register holds and the engine waits.
// Reset (synchronous, active low) empties the graph and sets the distance
// limit to all ones; i_cfg_we writes the limit and must only be used idle.
// ----------------------------------------------------------------------------
module shortest_path_tree_engine_top #(
    parameter int unsigned MAX_NODES = spte_pkg::DEF_MAX_NODES,
    parameter int unsigned MAX_EDGES = spte_pkg::DEF_MAX_EDGES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  spte_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_ready,
    output spte_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);
    import spte_pkg::*;

    localparam int unsigned NW  = $clog2(MAX_NODES);
    localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
    localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_DRAIN = 4'd2;
    localparam logic [3:0] ST_SEED  = 4'd3;
    localparam logic [3:0] ST_POP   = 4'd4;
    localparam logic [3:0] ST_POPW  = 4'd5;
    localparam logic [3:0] ST_NCOST = 4'd6;
    localparam logic [3:0] ST_ERD   = 4'd7;
    localparam logic [3:0] ST_ECHK  = 4'd8;
    localparam logic [3:0] ST_EUPD  = 4'd9;
    localparam logic [3:0] ST_ORD   = 4'd10;
    localparam logic [3:0] ST_OWAIT = 4'd11;

    logic [3:0]       r_state, n_state;
    logic [31:0]      r_max_dsq;
    logic [NW-1:0]    r_si;
    logic             r_p0_vld, r_p0_pres;
    logic [NW-1:0]    r_p0_idx;
    t_pos             r_ctr;
    logic             r_found;
    logic [DIST_W-1:0] r_best;
    logic [NW-1:0]    r_start, r_n, r_dst, r_oi;
    logic [COST_W-1:0] r_ncost, r_nc;
    logic [EW-1:0]    r_e;
    logic             r_ovld;
    t_out_item        r_out;

    logic             in_fire, out_free;
    t_pos             pos_rdata;
    logic [MAX_NODES-1:0] present;
    t_edge            edge_rdata;
    logic [EW-1:0]    edge_cnt;
    logic             d_vld, d_pres, d_busy;
    logic [NW-1:0]    d_idx;
    logic [DIST_W-1:0] d_dist;
    t_lbl_cmd         lcmd;
    t_label           lbl;
    logic [NW-1:0]    q_node;
    logic             q_empty;
    logic             edge_hit;
    logic [COST_W:0]  nc_sum;
    logic             oi_start, oi_reached;
    t_out_item        out_next;

    assign o_ready  = (r_state == ST_IDLE);
    assign in_fire  = i_valid && o_ready;
    assign out_free = !r_ovld || i_ready;

    spte_graph #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_graph (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (in_fire),
        .i_item       (i_in),
        .i_pos_raddr  (r_si),
        .o_pos_rdata  (pos_rdata),
        .o_present    (present),
        .i_edge_raddr (r_e[EAW-1:0]),
        .o_edge_rdata (edge_rdata),
        .o_edge_cnt   (edge_cnt)
    );

    spte_dist #(.MAX_NODES(MAX_NODES)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p0_vld),
        .i_idx   (r_p0_idx),
        .i_pres  (r_p0_pres),
        .i_pos   (pos_rdata),
        .i_ctr   (r_ctr),
        .o_vld   (d_vld),
        .o_idx   (d_idx),
        .o_pres  (d_pres),
        .o_dist  (d_dist),
        .o_busy  (d_busy)
    );

    spte_label #(.MAX_NODES(MAX_NODES)) u_label (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (lcmd),
        .o_rdata   (lbl),
        .o_q_node  (q_node),
        .o_q_empty (q_empty)
    );

    assign edge_hit = (edge_rdata.src == NODE_FW'(r_n));
    assign nc_sum   = (COST_W+1)'(r_ncost) + (COST_W+1)'(edge_rdata.weight);

    assign oi_start   = r_found && (r_oi == r_start);
    assign oi_reached = oi_start || lbl.prev_vld;
    always_comb begin
        out_next.node_index = NODE_FW'(r_oi);
        out_next.reached    = oi_reached;
        out_next.is_start   = oi_start;
        out_next.prev_node  = (oi_reached && !oi_start) ? lbl.prev : '0;
        out_next.path_cost  = oi_reached ? lbl.cost : COST_NONE;
        out_next.last       = (r_oi == NW'(MAX_NODES - 1));
    end

    always_comb begin
        lcmd    = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && i_in.req_type == REQ_RUN) begin
                    lcmd.clear = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_si == NW'(MAX_NODES - 1)) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!r_p0_vld && !d_busy && !d_vld) n_state = ST_SEED;
            end
            ST_SEED: begin
                if (r_found) begin
                    lcmd.wr        = 1'b1;
                    lcmd.wr_addr   = NODE_FW'(r_start);
                    lcmd.wr_data   = '{prev_vld: 1'b0, prev: '0, cost: '0};
                    lcmd.push      = 1'b1;
                    lcmd.push_node = NODE_FW'(r_start);
                end
                n_state = ST_POP;
            end
            ST_POP: begin
                if (q_empty) begin
                    n_state = ST_ORD;
                end else begin
                    lcmd.pop = 1'b1;
                    n_state  = ST_POPW;
                end
            end
            ST_POPW: begin
                lcmd.unmark      = 1'b1;
                lcmd.unmark_node = NODE_FW'(q_node);
                lcmd.rd          = 1'b1;
                lcmd.rd_addr     = NODE_FW'(q_node);
                n_state          = ST_NCOST;
            end
            ST_NCOST: n_state = ST_ERD;
            ST_ERD: begin
                n_state = (r_e == edge_cnt) ? ST_POP : ST_ECHK;
            end
            ST_ECHK: begin
                if (edge_hit) begin
                    lcmd.rd      = 1'b1;
                    lcmd.rd_addr = edge_rdata.dst;
                    n_state      = ST_EUPD;
                end else begin
                    n_state = ST_ERD;
                end
            end
            ST_EUPD: begin
                if (r_nc < lbl.cost) begin
                    lcmd.wr        = 1'b1;
                    lcmd.wr_addr   = NODE_FW'(r_dst);
                    lcmd.wr_data   = '{prev_vld: 1'b1, prev: NODE_FW'(r_n), cost: r_nc};
                    lcmd.push      = 1'b1;
                    lcmd.push_node = NODE_FW'(r_dst);
                end
                n_state = ST_ERD;
            end
            ST_ORD: begin
                lcmd.rd      = 1'b1;
                lcmd.rd_addr = NODE_FW'(r_oi);
                n_state      = ST_OWAIT;
            end
            ST_OWAIT: begin
                if (out_free) n_state = out_next.last ? ST_IDLE : ST_ORD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_max_dsq <= '1;
            r_p0_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_ovld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p0_vld <= (r_state == ST_SCAN);
            if (i_cfg_we) r_max_dsq <= i_cfg_wdata;
            if (in_fire && i_in.req_type == REQ_RUN) begin
                r_found <= 1'b0;
            end else if (d_vld && d_pres && d_dist < DIST_W'(r_max_dsq)
                         && (!r_found || d_dist < r_best)) begin
                r_found <= 1'b1;
            end
            if (r_state == ST_OWAIT && out_free) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0_idx  <= r_si;
        r_p0_pres <= present[r_si];
        if (d_vld && d_pres && d_dist < DIST_W'(r_max_dsq) && (!r_found || d_dist < r_best)) begin
            r_best  <= d_dist;
            r_start <= d_idx;
        end
        unique case (r_state)
            ST_IDLE: begin
                r_si  <= '0;
                r_ctr <= '{x: i_in.coord_x, y: i_in.coord_y, z: i_in.coord_z};
            end
            ST_SCAN:  r_si <= r_si + 1'b1;
            ST_POPW:  r_n <= q_node;
            ST_NCOST: begin
                r_ncost <= lbl.cost;
                r_e     <= '0;
            end
            ST_ERD:   r_e <= r_e + 1'b1;
            ST_ECHK: begin
                r_dst <= edge_rdata.dst[NW-1:0];
                r_nc  <= nc_sum[COST_W] ? COST_NONE : nc_sum[COST_W-1:0];
            end
            ST_POP:   r_oi <= '0;
            ST_OWAIT: begin
                if (out_free) begin
                    r_out <= out_next;
                    r_oi  <= r_oi + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_ovld;
    assign o_out   = r_out;

endmodule

// File: src/spte_graph.sv
// ----------------------------------------------------------------------------
// Graph store
// Node position memory, presence bits and the append-only edge memory.
// ----------------------------------------------------------------------------
module spte_graph #(
    parameter int unsigned MAX_NODES = spte_pkg::DEF_MAX_NODES,
    parameter int unsigned MAX_EDGES = spte_pkg::DEF_MAX_EDGES,
    localparam int unsigned NW  = $clog2(MAX_NODES),
    localparam int unsigned EW  = $clog2(MAX_EDGES + 1),
    localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_en,
    input  spte_pkg::t_in_item  i_item,
    input  logic [NW-1:0]       i_pos_raddr,
    output spte_pkg::t_pos      o_pos_rdata,
    output logic [MAX_NODES-1:0] o_present,
    input  logic [EAW-1:0]      i_edge_raddr,
    output spte_pkg::t_edge     o_edge_rdata,
    output logic [EW-1:0]       o_edge_cnt
);
    import spte_pkg::*;

    t_pos   r_pos_mem [MAX_NODES];
    t_edge  r_edge_mem [MAX_EDGES];
    logic [MAX_NODES-1:0] r_present;
    logic [EW-1:0]        r_edge_cnt;
    t_pos   r_pos_rdata;
    t_edge  r_edge_rdata;
    logic   node_ok;
    logic   edge_ok;

    assign node_ok = {1'b0, i_item.node_a} < 7'(MAX_NODES);
    assign edge_ok = node_ok && ({1'b0, i_item.node_b} < 7'(MAX_NODES))
                     && (i_item.weight != '0) && (r_edge_cnt < EW'(MAX_EDGES));

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_item.req_type == REQ_NODE && node_ok) begin
            r_pos_mem[i_item.node_a[NW-1:0]] <= '{x: i_item.coord_x, y: i_item.coord_y,
                                                  z: i_item.coord_z};
        end
        r_pos_rdata <= r_pos_mem[i_pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_item.req_type == REQ_EDGE && edge_ok) begin
            r_edge_mem[r_edge_cnt[EAW-1:0]] <= '{dst: i_item.node_a, src: i_item.node_b,
                                                 weight: i_item.weight};
        end
        r_edge_rdata <= r_edge_mem[i_edge_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= '0;
            r_edge_cnt <= '0;
        end else if (i_wr_en) begin
            unique case (i_item.req_type)
                REQ_NODE: begin
                    if (node_ok) r_present[i_item.node_a[NW-1:0]] <= 1'b1;
                end
                REQ_EDGE: begin
                    if (edge_ok) r_edge_cnt <= r_edge_cnt + 1'b1;
                end
                REQ_CLEAR: begin
                    r_present  <= '0;
                    r_edge_cnt <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_pos_rdata  = r_pos_rdata;
    assign o_edge_rdata = r_edge_rdata;
    assign o_present    = r_present;
    assign o_edge_cnt   = r_edge_cnt;

endmodule

// File: src/spte_dist.sv
// ----------------------------------------------------------------------------
// Squared distance unit
// Two-stage pipeline: per-axis squares, then their sum.
// ----------------------------------------------------------------------------
module spte_dist #(
    parameter int unsigned MAX_NODES = spte_pkg::DEF_MAX_NODES,
    localparam int unsigned NW = $clog2(MAX_NODES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [NW-1:0]                 i_idx,
    input  logic                          i_pres,
    input  spte_pkg::t_pos                i_pos,
    input  spte_pkg::t_pos                i_ctr,
    output logic                          o_vld,
    output logic [NW-1:0]                 o_idx,
    output logic                          o_pres,
    output logic [spte_pkg::DIST_W-1:0]   o_dist,
    output logic                          o_busy
);
    import spte_pkg::*;

    logic signed [COORD_W:0]     dx, dy, dz;
    logic signed [2*COORD_W+1:0] sx, sy, sz;
    logic [2*COORD_W-1:0]        r_sx, r_sy, r_sz;
    logic                        r_s1_vld, r_s2_vld;
    logic [NW-1:0]               r_s1_idx, r_s2_idx;
    logic                        r_s1_pres, r_s2_pres;
    logic [DIST_W-1:0]           r_dist;

    assign dx = (COORD_W+1)'(i_pos.x) - (COORD_W+1)'(i_ctr.x);
    assign dy = (COORD_W+1)'(i_pos.y) - (COORD_W+1)'(i_ctr.y);
    assign dz = (COORD_W+1)'(i_pos.z) - (COORD_W+1)'(i_ctr.z);
    assign sx = dx * dx;
    assign sy = dy * dy;
    assign sz = dz * dz;

    always_ff @(posedge i_clk) begin
        r_sx      <= sx[2*COORD_W-1:0];
        r_sy      <= sy[2*COORD_W-1:0];
        r_sz      <= sz[2*COORD_W-1:0];
        r_s1_idx  <= i_idx;
        r_s1_pres <= i_pres;
        r_dist    <= DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
        r_s2_idx  <= r_s1_idx;
        r_s2_pres <= r_s1_pres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    assign o_vld  = r_s2_vld;
    assign o_idx  = r_s2_idx;
    assign o_pres = r_s2_pres;
    assign o_dist = r_dist;
    assign o_busy = r_s1_vld || r_s2_vld;

endmodule

// File: src/spte_label.sv
// ----------------------------------------------------------------------------
// Label store
// Cost and predecessor memory with per-run valid bits, plus the work queue.
// ----------------------------------------------------------------------------
module spte_label #(
    parameter int unsigned MAX_NODES = spte_pkg::DEF_MAX_NODES,
    localparam int unsigned NW = $clog2(MAX_NODES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spte_pkg::t_lbl_cmd  i_cmd,
    output spte_pkg::t_label    o_rdata,
    output logic [NW-1:0]       o_q_node,
    output logic                o_q_empty
);
    import spte_pkg::*;

    t_label          r_mem [MAX_NODES];
    logic [NW-1:0]   r_q_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_vld;
    logic [MAX_NODES-1:0] r_mask;
    logic [NW-1:0]   r_head, r_tail;
    logic [NW:0]     r_cnt;
    t_label          r_rdata;
    logic            r_rd_vld;
    logic [NW-1:0]   r_q_rdata;
    logic            push_ok;
    logic [NW-1:0]   push_n;

    assign push_n  = i_cmd.push_node[NW-1:0];
    assign push_ok = i_cmd.push && !r_mask[push_n];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) r_mem[i_cmd.wr_addr[NW-1:0]] <= i_cmd.wr_data;
        if (i_cmd.rd) r_rdata <= r_mem[i_cmd.rd_addr[NW-1:0]];
        if (push_ok) r_q_mem[r_tail] <= push_n;
        if (i_cmd.pop) r_q_rdata <= r_q_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_vld    <= '0;
            r_mask   <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.wr) r_vld[i_cmd.wr_addr[NW-1:0]] <= 1'b1;
            if (i_cmd.rd) r_rd_vld <= r_vld[i_cmd.rd_addr[NW-1:0]];
            if (i_cmd.unmark) r_mask[i_cmd.unmark_node[NW-1:0]] <= 1'b0;
            if (push_ok) begin
                r_mask[push_n] <= 1'b1;
                r_tail <= (r_tail == NW'(MAX_NODES - 1)) ? '0 : r_tail + 1'b1;
            end
            if (i_cmd.pop) begin
                r_head <= (r_head == NW'(MAX_NODES - 1)) ? '0 : r_head + 1'b1;
            end
            r_cnt <= r_cnt + (NW+1)'(push_ok) - (NW+1)'(i_cmd.pop);
        end
    end

    // unwritten entries of this run read as unreached
    assign o_rdata   = r_rd_vld ? r_rdata : LABEL_NONE;
    assign o_q_node  = r_q_rdata;
    assign o_q_empty = (r_cnt == '0);

endmodule

// File: src/spte_checker.sv
// ----------------------------------------------------------------------------
// Shortest path tree engine port checker
// Concurrent checks on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "shortest_path_tree_engine_top_defines.svh"

module spte_checker #(
    parameter int unsigned MAX_NODES = spte_pkg::DEF_MAX_NODES
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input spte_pkg::t_out_item o_out
);
    import spte_pkg::*;

    `SPTE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_out), "result changed while stalled")

    `SPTE_ASSERT_NOW(a_run_busy, i_clk, i_rst_n, o_valid && !o_out.last,
        !o_ready, "input taken in the middle of a run")

    `SPTE_ASSERT_NOW(a_last_idx, i_clk, i_rst_n, o_valid && o_out.last,
        o_out.node_index == NODE_FW'(MAX_NODES - 1), "last flag on wrong node")

    `SPTE_ASSERT_NOW(a_start_cost, i_clk, i_rst_n, o_valid && o_out.is_start,
        o_out.reached && o_out.path_cost == '0 && o_out.prev_node == '0,
        "start node result malformed")

    `SPTE_ASSERT_NEXT_ALWAYS(a_rst_idle, i_clk, !i_rst_n, !o_valid && o_ready,
        "not idle after reset")

endmodule

bind shortest_path_tree_engine_top spte_checker #(.MAX_NODES(MAX_NODES)) u_spte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out       (o_out)
);
